// File: hw/rtl/bresenham_line_stepper_defines.svh
// Assertion macros for the line stepper checker.
`ifndef BRESENHAM_LINE_STEPPER_DEFINES_SVH
`define BRESENHAM_LINE_STEPPER_DEFINES_SVH

// Checked only outside reset.
`define BLS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked through reset as well.
`define BLS_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/bls_pkg.sv
// Types and constants shared by the line stepper modules.
package bls_pkg;

  localparam int COORD_BITS  = 10;
  localparam int ERR_BITS    = COORD_BITS + 2;
  localparam int COLOR_BITS  = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef logic [COORD_BITS-1:0]      coord_t;
  typedef logic signed [ERR_BITS-1:0] err_t;
  typedef logic [COLOR_BITS-1:0]      color_t;

  typedef enum logic {
    REQ_START = 1'b0,
    REQ_STEP  = 1'b1
  } req_t;

  // One classified word on its way from the front to the back.
  typedef struct packed {
    req_t   req;
    coord_t x0;
    coord_t y0;
    coord_t x1;
    coord_t y1;
    coord_t span_x;
    coord_t span_y;
    logic   dir_x_neg;
    logic   dir_y_neg;
    err_t   err_init;
    color_t color;
    logic   done;
  } cmd_t;

endpackage

// File: hw/rtl/bresenham_line_stepper.sv
// Top level of the Bresenham line stepper: front end, word queue and stepping back end.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+---------------------------------------------
//   in      | sink      | in_valid / in_ready | req_type, start_x/y, stop_x/y, pen_color
//   out     | source    | out_valid/out_ready | pix_x, pix_y, pix_color, last
//
// One word per cycle in steady state while the output is not stalled; a taken word is held
// in the two-entry queue, then its pixel is registered in the back end's output register.
// The back end's add-and-compare step of the error term sets the cycle time.
// A stalled output holds the back end; the queue keeps taking words until it is full.
// Synchronous reset empties the queue, clears the line state and drops any pending pixel.
module bresenham_line_stepper import bls_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  logic   req_type,
  input  coord_t start_x,
  input  coord_t start_y,
  input  coord_t stop_x,
  input  coord_t stop_y,
  input  color_t pen_color,
  output logic   out_valid,
  input  logic   out_ready,
  output coord_t pix_x,
  output coord_t pix_y,
  output color_t pix_color,
  output logic   last
);

  cmd_t front_cmd;
  cmd_t back_cmd;
  logic back_valid;
  logic back_ready;

  bls_front u_front (
    .req_type  (req_type),
    .start_x   (start_x),
    .start_y   (start_y),
    .stop_x    (stop_x),
    .stop_y    (stop_y),
    .pen_color (pen_color),
    .cmd       (front_cmd)
  );

  bls_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_cmd   (front_cmd),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_cmd    (back_cmd)
  );

  bls_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (back_valid),
    .cmd_ready (back_ready),
    .cmd       (back_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pix_x     (pix_x),
    .pix_y     (pix_y),
    .pix_color (pix_color),
    .last      (last)
  );

endmodule

// File: hw/rtl/bls_front.sv
// Front end: classify the incoming word and work out the line setup for a start.
module bls_front import bls_pkg::*; (
  input  logic   req_type,
  input  coord_t start_x,
  input  coord_t start_y,
  input  coord_t stop_x,
  input  coord_t stop_y,
  input  color_t pen_color,
  output cmd_t   cmd
);

  coord_t sx;
  coord_t sy;
  coord_t half_x;
  coord_t half_y;

  always_comb begin
    sx     = (stop_x > start_x) ? (stop_x - start_x) : (start_x - stop_x);
    sy     = (stop_y > start_y) ? (stop_y - start_y) : (start_y - stop_y);
    half_x = sx >> 1;
    half_y = sy >> 1;

    cmd.req       = req_t'(req_type);
    cmd.x0        = start_x;
    cmd.y0        = start_y;
    cmd.x1        = stop_x;
    cmd.y1        = stop_y;
    cmd.span_x    = sx;
    cmd.span_y    = sy;
    cmd.dir_x_neg = !(start_x < stop_x);
    cmd.dir_y_neg = !(start_y < stop_y);
    // Halve toward zero: shift the magnitude, then apply the sign.
    if (sx > sy) begin
      cmd.err_init = err_t'({2'b00, half_x});
    end else begin
      cmd.err_init = -err_t'({2'b00, half_y});
    end
    cmd.color = pen_color;
    cmd.done  = (start_x == stop_x) && (start_y == stop_y);
  end

endmodule

// File: hw/rtl/bls_queue.sv
// Short queue of classified words between front and back.
module bls_queue import bls_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  cmd_t                  slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr;
  logic [QUEUE_AW-1:0]   rd_ptr;
  logic [QUEUE_AW:0]     count;
  logic                  do_push;
  logic                  do_pop;

  assign push_ready = (count != (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: hw/rtl/bls_back.sv
// Back end: hold the line state, load a line per start word, take one step per step word and register the pixel.
module bls_back import bls_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   cmd_valid,
  output logic   cmd_ready,
  input  cmd_t   cmd,
  output logic   out_valid,
  input  logic   out_ready,
  output coord_t pix_x,
  output coord_t pix_y,
  output color_t pix_color,
  output logic   last
);

  coord_t cur_x, cur_y, goal_x, goal_y, span_x, span_y;
  logic   dir_x_neg, dir_y_neg, busy;
  err_t   err_term;
  color_t line_color;

  coord_t cur_x_next, cur_y_next, goal_x_next, goal_y_next, span_x_next, span_y_next;
  logic   dir_x_neg_next, dir_y_neg_next, busy_next;
  err_t   err_term_next;
  color_t line_color_next;

  logic   out_valid_next, last_next;
  coord_t pix_x_next, pix_y_next;
  color_t pix_color_next;

  logic   take;
  logic   move_x, move_y;
  err_t   sx_ext, sy_ext;
  coord_t step_x, step_y;
  err_t   step_err;

  assign cmd_ready = !out_valid || out_ready;
  assign take      = cmd_valid && cmd_ready;

  always_comb begin
    sx_ext   = err_t'({2'b00, span_x});
    sy_ext   = err_t'({2'b00, span_y});
    move_x   = err_term > -sx_ext;
    move_y   = err_term < sy_ext;
    step_err = err_term - (move_x ? sy_ext : '0) + (move_y ? sx_ext : '0);
    step_x   = move_x ? (dir_x_neg ? cur_x - 1'b1 : cur_x + 1'b1) : cur_x;
    step_y   = move_y ? (dir_y_neg ? cur_y - 1'b1 : cur_y + 1'b1) : cur_y;
  end

  always_comb begin
    cur_x_next      = cur_x;
    cur_y_next      = cur_y;
    goal_x_next     = goal_x;
    goal_y_next     = goal_y;
    span_x_next     = span_x;
    span_y_next     = span_y;
    dir_x_neg_next  = dir_x_neg;
    dir_y_neg_next  = dir_y_neg;
    err_term_next   = err_term;
    line_color_next = line_color;
    busy_next       = busy;

    out_valid_next  = out_valid && !out_ready;
    pix_x_next      = pix_x;
    pix_y_next      = pix_y;
    pix_color_next  = pix_color;
    last_next       = last;

    if (take) begin
      unique case (cmd.req)
        REQ_START: begin
          // Load a fresh line; any line in progress is dropped.
          cur_x_next      = cmd.x0;
          cur_y_next      = cmd.y0;
          goal_x_next     = cmd.x1;
          goal_y_next     = cmd.y1;
          span_x_next     = cmd.span_x;
          span_y_next     = cmd.span_y;
          dir_x_neg_next  = cmd.dir_x_neg;
          dir_y_neg_next  = cmd.dir_y_neg;
          err_term_next   = cmd.err_init;
          line_color_next = cmd.color;
          busy_next       = !cmd.done;
          out_valid_next  = 1'b1;
          pix_x_next      = cmd.x0;
          pix_y_next      = cmd.y0;
          pix_color_next  = cmd.color;
          last_next       = cmd.done;
        end
        REQ_STEP: begin
          // A step with no line in progress is dropped without a word.
          if (busy) begin
            cur_x_next     = step_x;
            cur_y_next     = step_y;
            err_term_next  = step_err;
            busy_next      = !((step_x == goal_x) && (step_y == goal_y));
            out_valid_next = 1'b1;
            pix_x_next     = step_x;
            pix_y_next     = step_y;
            pix_color_next = line_color;
            last_next      = (step_x == goal_x) && (step_y == goal_y);
          end
        end
        default: begin
          busy_next = busy;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x      <= '0;
      cur_y      <= '0;
      goal_x     <= '0;
      goal_y     <= '0;
      span_x     <= '0;
      span_y     <= '0;
      dir_x_neg  <= 1'b0;
      dir_y_neg  <= 1'b0;
      err_term   <= '0;
      line_color <= '0;
      busy       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      cur_x      <= cur_x_next;
      cur_y      <= cur_y_next;
      goal_x     <= goal_x_next;
      goal_y     <= goal_y_next;
      span_x     <= span_x_next;
      span_y     <= span_y_next;
      dir_x_neg  <= dir_x_neg_next;
      dir_y_neg  <= dir_y_neg_next;
      err_term   <= err_term_next;
      line_color <= line_color_next;
      busy       <= busy_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pix_x     <= pix_x_next;
    pix_y     <= pix_y_next;
    pix_color <= pix_color_next;
    last      <= last_next;
  end

endmodule

// File: hw/rtl/bls_checker.sv
// Port-level checks for the line stepper, bound to the top level.
`include "bresenham_line_stepper_defines.svh"

module bls_checker import bls_pkg::*; (
  input logic   clk,
  input logic   rst,
  input logic   in_ready,
  input logic   out_valid,
  input logic   out_ready,
  input coord_t pix_x,
  input coord_t pix_y,
  input color_t pix_color,
  input logic   last
);

  `BLS_ASSERT_RST(a_reset_drops_pixel, rst |=> !out_valid, "pixel word survived reset")
  `BLS_ASSERT_RST(a_reset_empties_queue, rst |=> in_ready, "queue not empty after reset")
  `BLS_ASSERT(a_stall_holds_pixel, out_valid && !out_ready |=> out_valid && $stable(pix_x) && $stable(pix_y) && $stable(pix_color) && $stable(last), "stalled pixel word changed")

endmodule

bind bresenham_line_stepper bls_checker u_bls_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .pix_x     (pix_x),
  .pix_y     (pix_y),
  .pix_color (pix_color),
  .last      (last)
);
